// ===== rtl/nlp_pkg.sv =====
`timescale 1ns / 1ps

package nlp_pkg;

   localparam int MAX_LITERAL_CHARS = 255;
   localparam int POS_WIDTH = $clog2(MAX_LITERAL_CHARS + 1);
   localparam int CHAR_WIDTH = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int END_WIDTH = 8;
   localparam int MAG_WIDTH = VALUE_WIDTH + 1;
   localparam int SUM_WIDTH = MAG_WIDTH + 4;

   localparam logic [MAG_WIDTH-1:0] MAG_CAP = {1'b1, {VALUE_WIDTH{1'b0}}};
   localparam logic [MAG_WIDTH-1:0] NEG_LIMIT = {2'b01, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_POS_SAT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_NEG_SAT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [4:0] NO_DIGIT = 5'h1F;

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DIGITS = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      PH_WS    = 7'b0000001,
      PH_PRE   = 7'b0000010,
      PH_LEAD  = 7'b0000100,
      PH_ZERO0 = 7'b0001000,
      PH_ZERO  = 7'b0010000,
      PH_DIG   = 7'b0100000,
      PH_DONE  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  start_literal;
   } nlp_item_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      status_type                    status;
      logic [END_WIDTH-1:0]          end_position;
      radix_type                     base_used;
   } nlp_result_type;

   function automatic logic [4:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= "0" && c <= "9") begin
         d = 5'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         d = 5'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         d = 5'(c - "A" + 8'd10);
      end
      return d;
   endfunction

   function automatic logic [4:0] radix_value(input radix_type r);
      logic [4:0] v;
      unique case (r)
         RADIX_BIN: v = 5'd2;
         RADIX_OCT: v = 5'd8;
         RADIX_DEC: v = 5'd10;
         RADIX_HEX: v = 5'd16;
         default:   v = 5'd10;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/nlp_req_if.sv =====
`timescale 1ns / 1ps

interface nlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       start_literal;

   modport source (output valid, output character, output start_literal, input ready);
   modport sink (input valid, input character, input start_literal, output ready);
endinterface

// ===== rtl/nlp_rsp_if.sv =====
`timescale 1ns / 1ps

interface nlp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;
   logic [7:0]         end_position;
   logic [1:0]         base_used;

   modport source (output valid, output value, output status, output end_position,
                   output base_used, input ready);
   modport sink (input valid, input value, input status, input end_position,
                 input base_used, output ready);
endinterface

// ===== rtl/nlp_core.sv =====
`timescale 1ns / 1ps

module nlp_core
   import nlp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  nlp_item_type   item,
   output logic           emit,
   output nlp_result_type result
);

   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   radix_type              radix_ff, radix_in;
   logic [MAG_WIDTH-1:0]   mag_ff, mag_in;
   logic                   ovf_ff, ovf_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   cend_ff, cend_in;
   logic                   seen_ff, seen_in;

   phase_type              cur_phase;
   logic                   cur_neg;
   radix_type              cur_radix;
   logic [MAG_WIDTH-1:0]   cur_mag;
   logic                   cur_ovf;
   logic [POS_WIDTH-1:0]   cur_pos;
   logic [POS_WIDTH-1:0]   cur_cend;
   logic                   cur_seen;

   logic [CHAR_WIDTH-1:0]  c;
   logic [4:0]             d;
   logic                   is_space;
   logic                   is_sign;
   logic                   pre_path;
   logic                   take;
   logic [SUM_WIDTH-1:0]   scaled;
   logic [SUM_WIDTH-1:0]   sum;

   // restart on start_literal
   always_comb begin
      cur_phase = item.start_literal ? PH_WS : phase_ff;
      cur_neg   = item.start_literal ? 1'b0 : neg_ff;
      cur_radix = item.start_literal ? RADIX_DEC : radix_ff;
      cur_mag   = item.start_literal ? '0 : mag_ff;
      cur_ovf   = item.start_literal ? 1'b0 : ovf_ff;
      cur_pos   = item.start_literal ? '0 : pos_ff;
      cur_cend  = item.start_literal ? '0 : cend_ff;
      cur_seen  = item.start_literal ? 1'b0 : seen_ff;
   end

   assign c        = item.character;
   assign d        = digit_of(c);
   assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
   assign is_sign  = (c == "+") || (c == "-");
   assign pre_path = (cur_phase == PH_WS && !is_space && !is_sign) ||
                     cur_phase == PH_PRE || cur_phase == PH_LEAD;

   always_comb begin
      unique case (cur_radix)
         RADIX_BIN: scaled = SUM_WIDTH'({cur_mag, 1'b0});
         RADIX_OCT: scaled = SUM_WIDTH'({cur_mag, 3'b000});
         RADIX_DEC: scaled = SUM_WIDTH'({cur_mag, 3'b000}) + SUM_WIDTH'({cur_mag, 1'b0});
         RADIX_HEX: scaled = SUM_WIDTH'({cur_mag, 4'b0000});
         default:   scaled = '0;
      endcase
      sum = scaled + SUM_WIDTH'(d);
   end

   always_comb begin
      phase_in = cur_phase;
      neg_in   = cur_neg;
      radix_in = cur_radix;
      mag_in   = cur_mag;
      ovf_in   = cur_ovf;
      pos_in   = cur_pos;
      cend_in  = cur_cend;
      seen_in  = cur_seen;
      emit     = 1'b0;
      take     = 1'b0;

      if (cur_phase != PH_DONE) begin
         if (cur_pos >= POS_WIDTH'(MAX_LITERAL_CHARS)) begin
            emit = 1'b1;
         end else begin
            pos_in = cur_pos + 1'b1;
            if (cur_phase == PH_WS && is_space) begin
               phase_in = PH_WS;
            end else if (cur_phase == PH_WS && is_sign) begin
               neg_in   = (c == "-");
               phase_in = PH_PRE;
            end else if (pre_path) begin
               priority if (c == "_") begin
                  phase_in = PH_LEAD;
               end else if (c == "0") begin
                  radix_in = RADIX_OCT;
                  take     = 1'b1;
                  phase_in = (cur_phase == PH_LEAD) ? PH_ZERO : PH_ZERO0;
               end else if (d >= 5'd1 && d <= 5'd9) begin
                  radix_in = RADIX_DEC;
                  take     = 1'b1;
                  phase_in = PH_DIG;
               end else begin
                  emit = 1'b1;
               end
            end else if (cur_phase == PH_ZERO0 || cur_phase == PH_ZERO) begin
               priority if (c == "x" || c == "X") begin
                  radix_in = RADIX_HEX;
                  phase_in = PH_DIG;
               end else if (c == "b" && cur_phase == PH_ZERO0) begin
                  radix_in = RADIX_BIN;
                  phase_in = PH_DIG;
               end else if (c == "_") begin
                  phase_in = PH_ZERO;
               end else if (d < 5'd8) begin
                  take     = 1'b1;
                  phase_in = PH_DIG;
               end else begin
                  emit = 1'b1;
               end
            end else if (cur_phase == PH_DIG) begin
               priority if (c == "_") begin
                  phase_in = PH_DIG;
               end else if (d < radix_value(cur_radix)) begin
                  take = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end else begin
               emit = 1'b1;
            end
         end
      end

      if (take) begin
         if (sum > SUM_WIDTH'({VALUE_WIDTH{1'b1}})) begin
            ovf_in = 1'b1;
            mag_in = MAG_CAP;
         end else begin
            mag_in = sum[MAG_WIDTH-1:0];
         end
         seen_in = 1'b1;
         cend_in = cur_pos + 1'b1;
      end

      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   always_comb begin
      result.base_used    = cur_radix;
      result.end_position = END_WIDTH'(cur_cend);
      result.status       = STATUS_OK;
      result.value        = cur_mag[VALUE_WIDTH-1:0];
      if (!cur_seen) begin
         result.value        = '0;
         result.status       = STATUS_NO_DIGITS;
         result.end_position = '0;
      end else if (cur_neg) begin
         if (cur_ovf || cur_mag > NEG_LIMIT) begin
            result.value  = VALUE_NEG_SAT;
            result.status = STATUS_RANGE;
         end else begin
            result.value = -cur_mag[VALUE_WIDTH-1:0];
         end
      end else if (cur_ovf || cur_mag[VALUE_WIDTH]) begin
         result.value  = VALUE_POS_SAT;
         result.status = STATUS_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         neg_ff   <= 1'b0;
         radix_ff <= RADIX_DEC;
         mag_ff   <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
         cend_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         radix_ff <= radix_in;
         mag_ff   <= mag_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
         cend_ff  <= cend_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== rtl/numeric_literal_parser_top.sv =====
`timescale 1ns / 1ps

// Integer literal parser, one character per transaction.
// req_chan carries a character and start_literal; start_literal marks the
// first character of a new literal and restarts the parse with it.
// rsp_chan carries one transaction per literal: value, status (ok, no
// digits, out of range), end_position and base_used. It is sent when the
// character that ends the literal arrives; that character is not consumed.
// Characters after a finished literal are dropped until the next
// start_literal.
// Throughput: one character per cycle. The per-character accumulate
// (shift-add by the radix plus the digit) sits between the input register
// and the parse state; the response register is loaded from its result.
// When rsp_chan stalls, characters that yield no response keep flowing;
// a character that would end a literal waits in the input register until
// the response register frees, and req_chan.ready drops behind it.
// Reset (synchronous) empties both registers and leaves the parser as if
// a literal had just started.
module numeric_literal_parser_top
   import nlp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   nlp_req_if.sink   req_chan,
   nlp_rsp_if.source rsp_chan
);

   logic           s1_valid_ff;
   nlp_item_type   s1_item_ff;
   logic           rsp_valid_ff;
   nlp_result_type rsp_data_ff;

   logic           emit;
   nlp_result_type result;
   logic           out_free;
   logic           fire;
   logic           req_take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = s1_valid_ff && (!emit || out_free);
   assign req_chan.ready = !s1_valid_ff || fire;
   assign req_take = req_chan.valid && req_chan.ready;

   nlp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .item    (s1_item_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.character     <= req_chan.character;
         s1_item_ff.start_literal <= req_chan.start_literal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.value        = rsp_data_ff.value;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.end_position = rsp_data_ff.end_position;
   assign rsp_chan.base_used    = rsp_data_ff.base_used;

endmodule

// ===== rtl/nlp_checker.sv =====
`timescale 1ns / 1ps

module nlp_checker
   import nlp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value,
   input logic [1:0]         rsp_status,
   input logic [7:0]         rsp_end_position,
   input logic [1:0]         rsp_base_used
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_status) && $stable(rsp_end_position) && $stable(rsp_base_used))
      else $error("stalled response changed");

   a_no_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NO_DIGITS |-> rsp_value == 0 && rsp_end_position == 0)
      else $error("no-digit response with value or end position");

   a_range_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |->
      rsp_value == VALUE_POS_SAT || rsp_value == VALUE_NEG_SAT)
      else $error("overflow response not saturated");

   a_end_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_NO_DIGITS |-> rsp_end_position != 0)
      else $error("digits consumed but end position is zero");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind numeric_literal_parser_top nlp_checker u_nlp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_value        (rsp_chan.value),
   .rsp_status       (rsp_chan.status),
   .rsp_end_position (rsp_chan.end_position),
   .rsp_base_used    (rsp_chan.base_used)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import nlp_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int CHAR_TARGET = 1450;

   class literal_tracker;
      phase_type            phase;
      bit                   neg;
      radix_type            radix;
      logic [MAG_WIDTH-1:0] mag;
      bit                   ovf;
      int unsigned          char_pos;
      int unsigned          consumed;
      bit                   seen;
      nlp_result_type       pending_literals[$];
      int                   errors;
      int                   n_ok;
      int                   n_range;
      int                   n_nodig;

      function new();
         errors = 0;
         n_ok = 0;
         n_range = 0;
         n_nodig = 0;
         restart();
      endfunction

      function void restart();
         phase = PH_WS;
         neg = 1'b0;
         radix = RADIX_DEC;
         mag = '0;
         ovf = 1'b0;
         char_pos = 0;
         consumed = 0;
         seen = 1'b0;
      endfunction

      function int unsigned char_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return 255;
      endfunction

      function int unsigned radix_base(radix_type r);
         case (r)
            RADIX_BIN: return 2;
            RADIX_OCT: return 8;
            RADIX_HEX: return 16;
            default:   return 10;
         endcase
      endfunction

      function void take_digit(int unsigned d, int unsigned pos);
         logic [36:0] m;
         m = 37'(mag) * 37'(radix_base(radix)) + 37'(d);
         if (m > 37'h0_FFFF_FFFF) begin
            ovf = 1'b1;
            m = 37'h1_0000_0000;
         end
         mag = m[MAG_WIDTH-1:0];
         seen = 1'b1;
         consumed = pos + 1;
      endfunction

      function void close_literal();
         nlp_result_type r;
         r.base_used = radix;
         r.end_position = 8'(consumed);
         r.status = STATUS_OK;
         if (!seen) begin
            r.value = '0;
            r.status = STATUS_NO_DIGITS;
            r.end_position = '0;
         end else if (neg) begin
            if (ovf || mag > 33'h0_8000_0000) begin
               r.value = VALUE_NEG_SAT;
               r.status = STATUS_RANGE;
            end else begin
               r.value = -mag[31:0];
            end
         end else begin
            if (ovf || mag > 33'h0_FFFF_FFFF) begin
               r.value = VALUE_POS_SAT;
               r.status = STATUS_RANGE;
            end else begin
               r.value = mag[31:0];
            end
         end
         pending_literals.push_back(r);
         phase = PH_DONE;
      endfunction

      function void note_char(logic [7:0] c, bit s);
         int unsigned pos;
         int unsigned d;
         if (s) restart();
         if (phase == PH_DONE) return;
         pos = char_pos;
         if (pos >= MAX_LITERAL_CHARS) begin
            close_literal();
            return;
         end
         char_pos = pos + 1;
         d = char_digit(c);
         if (phase == PH_WS) begin
            if (c == " " || (c >= 9 && c <= 13)) return;
            if (c == "+" || c == "-") begin
               neg = (c == "-");
               phase = PH_PRE;
               return;
            end
         end
         case (phase)
            PH_WS, PH_PRE, PH_LEAD: begin
               if (c == "_") begin
                  phase = PH_LEAD;
               end else if (c == "0") begin
                  radix = RADIX_OCT;
                  take_digit(0, pos);
                  phase = (phase == PH_LEAD) ? PH_ZERO : PH_ZERO0;
               end else if (d >= 1 && d <= 9) begin
                  radix = RADIX_DEC;
                  take_digit(d, pos);
                  phase = PH_DIG;
               end else begin
                  close_literal();
               end
            end
            PH_ZERO0, PH_ZERO: begin
               if (c == "x" || c == "X") begin
                  radix = RADIX_HEX;
                  phase = PH_DIG;
               end else if (c == "b" && phase == PH_ZERO0) begin
                  radix = RADIX_BIN;
                  phase = PH_DIG;
               end else if (c == "_") begin
                  phase = PH_ZERO;
               end else if (d < 8) begin
                  take_digit(d, pos);
                  phase = PH_DIG;
               end else begin
                  close_literal();
               end
            end
            PH_DIG: begin
               if (c == "_") return;
               if (d < radix_base(radix)) begin
                  take_digit(d, pos);
               end else begin
                  close_literal();
               end
            end
            default: close_literal();
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] e, logic [31:0] a);
         if (a !== e) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
            errors++;
         end
      endfunction

      function void check_literal(nlp_result_type got);
         nlp_result_type exp;
         if (pending_literals.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual value %h status %0d",
                     $time, got.value, got.status);
            errors++;
            return;
         end
         exp = pending_literals.pop_front();
         case (exp.status)
            STATUS_OK:    n_ok++;
            STATUS_RANGE: n_range++;
            default:      n_nodig++;
         endcase
         compare_field("value", exp.value, got.value);
         compare_field("status", 32'(exp.status), 32'(got.status));
         compare_field("end_position", 32'(exp.end_position), 32'(got.end_position));
         compare_field("base_used", 32'(exp.base_used), 32'(got.base_used));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   nlp_req_if req_chan();
   nlp_rsp_if rsp_chan();

   numeric_literal_parser_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   literal_tracker lits;
   logic [7:0]     text_q[$];
   logic [7:0]     ws_chars[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
   bit             tx_burst;
   bit             rx_burst;
   int             items_sent;
   int             literal_count;
   int             stall_cycles;

   always @(posedge clock) begin
      nlp_result_type got;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.value = rsp_chan.value;
            got.status = status_type'(rsp_chan.status);
            got.end_position = rsp_chan.end_position;
            got.base_used = radix_type'(rsp_chan.base_used);
            lits.check_literal(got);
         end
         if (req_chan.valid && req_chan.ready) begin
            lits.note_char(req_chan.character, req_chan.start_literal);
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      while (stall_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : rsp_drive
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_char(input logic [7:0] c, input bit s);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.character <= c;
      req_chan.start_literal <= s;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_literal();
      tx_burst = ($urandom_range(0, 4) == 0);
      foreach (text_q[i]) send_char(text_q[i], i == 0);
      items_sent += text_q.size();
      literal_count++;
      text_q.delete();
   endtask

   // hold off the sender until every expected result is out
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (lits.pending_literals.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic void add_str(string s);
      foreach (s[i]) text_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] digit_char(int unsigned d, bit upper);
      if (d < 10) return 8'("0" + d);
      return upper ? 8'("A" + d - 10) : 8'("a" + d - 10);
   endfunction

   function automatic void add_number();
      longint unsigned v;
      int unsigned     base;
      int              sel;
      bit              upper;
      logic [7:0]      digs[$];
      logic [7:0]      term;
      repeat ($urandom_range(0, 2)) text_q.push_back(ws_chars[$urandom_range(0, 5)]);
      case ($urandom_range(0, 2))
         0: text_q.push_back("+");
         1: text_q.push_back("-");
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 64'h7FFF_FFFF;
         2: v = 64'h8000_0000;
         3: v = 64'h8000_0001;
         4: v = 64'hFFFF_FFFF;
         5: v = 64'h1_0000_0000 + $urandom;
         6: v = $urandom_range(0, 999);
         9: v = {$urandom, $urandom} >> $urandom_range(0, 40);
         default: v = $urandom;
      endcase
      sel = $urandom_range(0, 3);
      upper = $urandom_range(0, 1);
      case (sel)
         0: begin
            base = 2;
            add_str("0b");
         end
         1: begin
            base = 8;
            if ($urandom_range(0, 5) == 0) text_q.push_back("_");
            text_q.push_back("0");
         end
         3: begin
            base = 16;
            add_str(upper ? "0X" : "0x");
         end
         default: begin
            base = 10;
            if ($urandom_range(0, 7) == 0) text_q.push_back("_");
         end
      endcase
      if ($urandom_range(0, 7) == 0) text_q.push_back("_");
      if (v == 0) digs.push_front("0");
      while (v != 0) begin
         digs.push_front(digit_char(32'(v % base), upper));
         v = v / base;
      end
      foreach (digs[i]) begin
         if (i > 0 && $urandom_range(0, 7) == 0) text_q.push_back("_");
         text_q.push_back(digs[i]);
      end
      do term = 8'($urandom_range(0, 255));
      while (lits.char_digit(term) != 255 || term == "_");
      text_q.push_back(term);
   endfunction

   function automatic void add_long_literal();
      int n;
      n = $urandom_range(250, 300);
      if ($urandom_range(0, 2) == 0) begin
         repeat (n) text_q.push_back(8'd32);
      end else begin
         text_q.push_back("1");
         repeat (n - 1) begin
            case ($urandom_range(0, 2))
               0: text_q.push_back("0");
               1: text_q.push_back("1");
               default: text_q.push_back("_");
            endcase
         end
      end
      text_q.push_back(";");
   endfunction

   function automatic void add_random_literal();
      int kind;
      kind = $urandom_range(0, 99);
      if (literal_count == 20 || kind == 99) begin
         add_long_literal();
      end else if (kind < 72) begin
         add_number();
      end else if (kind < 86) begin
         repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_number();
         case ($urandom_range(0, 3))
            0: text_q.insert($urandom_range(0, text_q.size() - 1),
                             8'($urandom_range(0, 255)));
            1: begin
               text_q.push_front($urandom_range(0, 1) ? "+" : " ");
               text_q.push_front($urandom_range(0, 1) ? "-" : "+");
            end
            2: begin
               text_q.delete();
               add_str("0_b1");
               text_q.push_back(";");
            end
            default: void'(text_q.pop_back());
         endcase
      end
   endfunction

   initial begin
      lits = new();
      items_sent = 0;
      literal_count = 0;
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.character <= '0;
      req_chan.start_literal <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      text_q = {8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
      add_str("-0x80000001");
      text_q.push_back(8'hFF);
      send_literal();
      add_str("0b");
      text_q.push_back(8'h00);
      send_literal();
      add_str("0xg");
      send_literal();
      add_str("0_b");
      send_literal();
      add_str("+-1");
      send_literal();
      add_str("0 ");
      send_literal();
      add_str("z");
      send_literal();
      send_char("9", 1'b0);
      add_str("4294967295;");
      send_literal();
      add_str("0777_8");
      send_literal();
      drain();

      while (items_sent < CHAR_TARGET) begin
         add_random_literal();
         send_literal();
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
         end
         if ($urandom_range(0, 29) == 0) drain();
      end
      req_chan.valid <= 1'b0;
      while (lits.pending_literals.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d characters in %0d literals", items_sent, literal_count);
      $display("Checked results: %0d ok, %0d out of range, %0d without digits",
               lits.n_ok, lits.n_range, lits.n_nodig);
      if (lits.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/nlp_pkg.sv
rtl/nlp_req_if.sv
rtl/nlp_rsp_if.sv
rtl/nlp_core.sv
rtl/numeric_literal_parser_top.sv
rtl/nlp_checker.sv
test/tb.sv
